### rtl/stq_pkg.sv
// stq_pkg: shared constants, codes and item types for the sorted timer queue.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps
package stq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int NUM_FIFOS  = 16;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int TID_W      = 4;
  localparam int FID_W      = 4;
  localparam int DL_W       = 32;
  localparam int ID_LIMIT   = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;

  localparam logic [2:0] MODE_ALLOC = 3'd0;
  localparam logic [2:0] MODE_FREE  = 3'd1;
  localparam logic [2:0] MODE_BIND  = 3'd2;
  localparam logic [2:0] MODE_ARM   = 3'd3;
  localparam logic [2:0] MODE_TICK  = 3'd4;

  localparam logic [1:0] K_DONE   = 2'd0;
  localparam logic [1:0] K_ALLOC  = 2'd1;
  localparam logic [1:0] K_REFUSE = 2'd2;
  localparam logic [1:0] K_EXPIRE = 2'd3;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  typedef struct packed {
    logic [2:0]        mode;
    logic [TID_W-1:0]  timer_id;
    logic [FID_W-1:0]  fifo_id;
    logic signed [31:0] data;
    logic [31:0]       timeout;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TID_W-1:0]  timer_id_out;
    logic [FID_W-1:0]  fifo_id_out;
    logic signed [31:0] data_out;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] id;
    logic [DL_W-1:0]  dl;
  } cell_t;

  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [DL_W-1:0]  key;
    logic [IDX_W-1:0] id;
  } chain_ctl_t;

endpackage

### rtl/sorted_timeout_timer_queue.sv
// sorted_timeout_timer_queue: timer pool with command sequencer and a
// deadline-sorted cell chain. Depends on stq_pkg and stq_chain.
//
//   channel | ports                     | dir | payload
//   in      | in_valid/in_ready         | in  | in_item  (in_item_t)
//   out     | out_valid/out_ready       | out | out_item (out_item_t)
//
// One item at a time. Allocate, free, bind, arm and unknown modes load the
// result register from S_EXEC, once the output slot is free after accept.
// A tick pops the expired timers from the head of the cell chain, one pop per
// cycle while the output slot is free. Arm inserts into the chain.
// Reset (rst_n, synchronous) clears tick count, timer status and queue.
// A stalled result holds the sequencer in place until out_ready.
`timescale 1ns / 1ps
module sorted_timeout_timer_queue
  import stq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_POP} state_t;

  state_t           state_r;
  in_item_t         cmd_r;
  logic [DL_W-1:0]  tick_r;
  logic [1:0]       status_r [NUM_TIMERS];
  logic [FID_W-1:0] fifo_r   [NUM_TIMERS];
  logic [31:0]      data_r   [NUM_TIMERS];
  logic             out_valid_r;
  out_item_t        out_item_r;
  out_item_t        out_item_nxt;
  logic             load_out;

  chain_ctl_t       ctl;
  cell_t            head, second;
  logic             slot_free, head_exp, next_exp;
  logic             tid_ok, fid_ok, op_ok;
  logic [IDX_W-1:0] tid_idx;
  logic [1:0]       tid_status;
  logic             alloc_found;
  logic [IDX_W-1:0] alloc_idx;
  out_item_t        exec_res, exp_res;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign head_exp  = head.vld && (head.dl <= tick_r);
  assign next_exp  = second.vld && (second.dl <= tick_r);

  assign tid_ok     = int'(cmd_r.timer_id) < NUM_TIMERS;
  assign fid_ok     = int'(cmd_r.fifo_id) < NUM_FIFOS;
  assign tid_idx    = IDX_W'(cmd_r.timer_id);
  assign tid_status = status_r[tid_idx];

  always_comb begin
    alloc_found = 1'b0;
    alloc_idx   = '0;
    for (int i = ID_LIMIT-1; i >= 0; i--) begin
      if (status_r[i] == ST_FREE) begin
        alloc_found = 1'b1;
        alloc_idx   = IDX_W'(i);
      end
    end
  end

  // an allocated timer is never in the queue, so an arm always finds room
  always_comb begin
    exec_res      = '0;
    exec_res.last = 1'b1;
    op_ok         = 1'b0;
    case (cmd_r.mode)
      MODE_ALLOC: begin
        op_ok = alloc_found;
        if (alloc_found) begin
          exec_res.kind         = K_ALLOC;
          exec_res.timer_id_out = TID_W'(alloc_idx);
        end else begin
          exec_res.kind = K_REFUSE;
        end
      end
      MODE_FREE: begin
        op_ok = tid_ok && (tid_status != ST_RUN);
        exec_res.kind = op_ok ? K_DONE : K_REFUSE;
      end
      MODE_BIND: begin
        op_ok = tid_ok && fid_ok;
        exec_res.kind = op_ok ? K_DONE : K_REFUSE;
      end
      MODE_ARM: begin
        op_ok = tid_ok && (tid_status == ST_ALLOC);
        exec_res.kind = op_ok ? K_DONE : K_REFUSE;
      end
      default: begin
        exec_res.kind = K_DONE;
      end
    endcase
  end

  always_comb begin
    exp_res              = '0;
    exp_res.kind         = K_EXPIRE;
    exp_res.timer_id_out = TID_W'(head.id);
    exp_res.fifo_id_out  = fifo_r[head.id];
    exp_res.data_out     = data_r[head.id];
    exp_res.last         = !next_exp;
  end

  assign load_out = slot_free && ((state_r == S_EXEC) || (state_r == S_POP));

  always_comb begin
    out_item_nxt = exec_res;
    if (state_r == S_POP) begin
      if (head_exp) begin
        out_item_nxt = exp_res;
      end else begin
        out_item_nxt      = '0;
        out_item_nxt.kind = K_DONE;
        out_item_nxt.last = 1'b1;
      end
    end
  end

  always_comb begin
    ctl     = '0;
    ctl.key = tick_r + cmd_r.timeout;
    ctl.id  = tid_idx;
    ctl.ins = (state_r == S_EXEC) && slot_free && (cmd_r.mode == MODE_ARM) && op_ok;
    ctl.pop = (state_r == S_POP) && slot_free && head_exp;
  end

  stq_chain u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .head   (head),
    .second (second)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tick_r      <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        status_r[i] <= ST_FREE;
      end
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
        out_item_r  <= out_item_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_item;
            if (in_item.mode == MODE_TICK) begin
              tick_r  <= tick_r + 1'b1;
              state_r <= S_POP;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            state_r <= S_IDLE;
            if (op_ok) begin
              case (cmd_r.mode)
                MODE_ALLOC: status_r[alloc_idx] <= ST_ALLOC;
                MODE_FREE:  status_r[tid_idx]   <= ST_FREE;
                MODE_BIND: begin
                  fifo_r[tid_idx] <= cmd_r.fifo_id;
                  data_r[tid_idx] <= cmd_r.data;
                end
                MODE_ARM:   status_r[tid_idx]   <= ST_RUN;
                default: ;
              endcase
            end
          end
        end
        S_POP: begin
          if (slot_free) begin
            if (head_exp) begin
              status_r[head.id] <= ST_ALLOC;
              if (!next_exp) begin
                state_r <= S_IDLE;
              end
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/stq_cell.sv
// stq_cell: one slot of the deadline-sorted queue; shifts toward the tail on
// insert and toward the head on pop. Depends on stq_pkg.
`timescale 1ns / 1ps
module stq_cell
  import stq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl,
  input  cell_t      prev_cell,
  input  logic       prev_after,
  input  cell_t      next_cell,
  output cell_t      own_cell,
  output logic       after
);

  logic             vld_r, vld_nxt;
  logic [IDX_W-1:0] id_r, id_nxt;
  logic [DL_W-1:0]  dl_r, dl_nxt;

  always_comb begin
    after   = !vld_r || (ctl.key <= dl_r);
    vld_nxt = vld_r;
    id_nxt  = id_r;
    dl_nxt  = dl_r;
    if (ctl.ins) begin
      if (after && prev_after) begin
        vld_nxt = prev_cell.vld;
        id_nxt  = prev_cell.id;
        dl_nxt  = prev_cell.dl;
      end else if (after) begin
        vld_nxt = 1'b1;
        id_nxt  = ctl.id;
        dl_nxt  = ctl.key;
      end
    end else if (ctl.pop) begin
      vld_nxt = next_cell.vld;
      id_nxt  = next_cell.id;
      dl_nxt  = next_cell.dl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    dl_r <= dl_nxt;
  end

  assign own_cell = '{vld: vld_r, id: id_r, dl: dl_r};

endmodule

### rtl/stq_chain.sv
// stq_chain: row of stq_cell slots forming the sorted run queue, head at 0.
// Depends on stq_pkg and stq_cell.
`timescale 1ns / 1ps
module stq_chain
  import stq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl,
  output cell_t      head,
  output cell_t      second
);

  cell_t                 cells     [NUM_TIMERS];
  logic                  afters    [NUM_TIMERS];
  cell_t                 prev_c    [NUM_TIMERS];
  logic                  prev_a    [NUM_TIMERS];
  cell_t                 next_c    [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] vld_vec;

  always_comb begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      prev_c[i]  = (i == 0) ? '0 : cells[(i == 0) ? 0 : i-1];
      prev_a[i]  = (i == 0) ? 1'b0 : afters[(i == 0) ? 0 : i-1];
      next_c[i]  = (i == NUM_TIMERS-1) ? '0 : cells[(i == NUM_TIMERS-1) ? i : i+1];
      vld_vec[i] = cells[i].vld;
    end
  end

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    stq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_cell  (prev_c[g]),
      .prev_after (prev_a[g]),
      .next_cell  (next_c[g]),
      .own_cell   (cells[g]),
      .after      (afters[g])
    );
  end

  assign head   = cells[0];
  assign second = cells[1];

  a_no_ins_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.ins && ctl.pop))
    else $error("insert and pop in same cycle");

  a_vld_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec & (vld_vec + 1'b1)) == '0))
    else $error("queue valid bits not packed at head");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> cells[0].vld)
    else $error("pop from empty queue");

  a_ins_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |-> !cells[NUM_TIMERS-1].vld)
    else $error("insert into full queue");

endmodule

### sim/sorted_timeout_timer_queue_test.sv
// sorted_timeout_timer_queue_test: self-checking bench for the sorted timer queue.
// Tracks the timer pool and deadline queue in step with each accepted command.
// Depends on stq_pkg and the RTL under rtl/.
`timescale 1ns / 1ps
module sorted_timeout_timer_queue_test;
  import stq_pkg::*;

  localparam logic [2:0]  MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  MODE_UNUSED_LAST  = 3'd7;
  localparam int          MAX_POPS          = 16;
  localparam logic [31:0] TIMEOUT_MAX       = 32'hffffffff;
  localparam int unsigned RUN_LIMIT_NS      = 20_000_000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // pool state as seen from the command stream
  logic [31:0] tick_cnt;
  logic [1:0]  tstat [NUM_TIMERS];
  logic [31:0] dl [NUM_TIMERS];
  logic [3:0]  bfifo [NUM_TIMERS];
  logic [31:0] bdata [NUM_TIMERS];
  bit          bound_ever [NUM_TIMERS];
  logic [3:0]  deadline_order[$];
  out_item_t   awaited_results[$];

  int idle_pct = 0;
  int rdy_hold = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int expiry_cnt = 0;
  int refusal_cnt = 0;
  int burst_run = 0;
  int burst_max = 0;
  int errors = 0;
  out_item_t want;

  sorted_timeout_timer_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(40, 10);
    return $urandom_range(3, 1);
  endfunction

  always @(negedge clk) begin
    if (rdy_hold > 0) begin
      out_ready <= 1'b0;
      rdy_hold = rdy_hold - 1;
    end else begin
      out_ready <= 1'b1;
      rdy_hold = pick_gap();
    end
  end

  task automatic timer_pool_step(input in_item_t it);
    out_item_t r;
    int i, pos, n;
    bit found;
    logic [3:0] t;
    r = '0;
    r.kind = K_DONE;
    r.last = 1'b1;
    t = it.timer_id;
    case (it.mode)
      MODE_ALLOC: begin
        found = 1'b0;
        r.kind = K_REFUSE;
        for (i = 0; i < ID_LIMIT; i++) begin
          if (!found && tstat[i] == ST_FREE) begin
            tstat[i] = ST_ALLOC;
            r.kind = K_ALLOC;
            r.timer_id_out = TID_W'(i);
            found = 1'b1;
          end
        end
        awaited_results.push_back(r);
      end
      MODE_FREE: begin
        if (int'(t) >= NUM_TIMERS || tstat[t] == ST_RUN) r.kind = K_REFUSE;
        else tstat[t] = ST_FREE;
        awaited_results.push_back(r);
      end
      MODE_BIND: begin
        if (int'(t) >= NUM_TIMERS || int'(it.fifo_id) >= NUM_FIFOS) begin
          r.kind = K_REFUSE;
        end else begin
          bfifo[t] = it.fifo_id;
          bdata[t] = it.data;
          bound_ever[t] = 1'b1;
        end
        awaited_results.push_back(r);
      end
      MODE_ARM: begin
        if (int'(t) >= NUM_TIMERS || tstat[t] != ST_ALLOC ||
            deadline_order.size() >= NUM_TIMERS) begin
          r.kind = K_REFUSE;
        end else begin
          dl[t] = tick_cnt + it.timeout;
          tstat[t] = ST_RUN;
          pos = 0;
          while (pos < deadline_order.size() && dl[t] > dl[deadline_order[pos]]) pos++;
          deadline_order.insert(pos, t);
        end
        awaited_results.push_back(r);
      end
      MODE_TICK: begin
        tick_cnt = tick_cnt + 1;
        n = 0;
        while (deadline_order.size() > 0 && n < MAX_POPS &&
               dl[deadline_order[0]] <= tick_cnt) begin
          t = deadline_order.pop_front();
          tstat[t] = ST_ALLOC;
          r.kind = K_EXPIRE;
          r.timer_id_out = t;
          r.fifo_id_out = bfifo[t];
          r.data_out = bdata[t];
          n++;
          r.last = !(deadline_order.size() > 0 && n < MAX_POPS &&
                     dl[deadline_order[0]] <= tick_cnt);
          awaited_results.push_back(r);
        end
        if (n == 0) awaited_results.push_back(r);
      end
      default: awaited_results.push_back(r);
    endcase
  endtask

  function automatic void field_chk(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        field_chk("kind", 32'(want.kind), 32'(out_item.kind));
        field_chk("timer_id_out", 32'(want.timer_id_out), 32'(out_item.timer_id_out));
        field_chk("fifo_id_out", 32'(want.fifo_id_out), 32'(out_item.fifo_id_out));
        field_chk("data_out", want.data_out, out_item.data_out);
        field_chk("last", 32'(want.last), 32'(out_item.last));
        checked_cnt++;
        if (want.kind == K_REFUSE) refusal_cnt++;
        if (want.kind == K_EXPIRE) begin
          expiry_cnt++;
          burst_run++;
        end
        if (want.last) begin
          if (burst_run > burst_max) burst_max = burst_run;
          burst_run = 0;
        end
      end
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    timer_pool_step(it);
    sent_cnt++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() > 0) @(posedge clk);
  endtask

  // unused fields carry random junk
  function automatic in_item_t make_cmd(logic [2:0] mode, logic [3:0] tid);
    in_item_t c;
    c.mode = mode;
    c.timer_id = tid;
    c.fifo_id = 4'($urandom_range(15));
    c.data = $urandom;
    c.timeout = $urandom;
    return c;
  endfunction

  task automatic bind_timer(input logic [3:0] t, input logic [3:0] f, input logic [31:0] d);
    in_item_t c;
    c = make_cmd(MODE_BIND, t);
    c.fifo_id = f;
    c.data = d;
    send_item(c);
  endtask

  // an armed timer must carry a binding before it can expire
  task automatic arm_timer(input logic [3:0] t, input logic [31:0] tmo);
    in_item_t c;
    if (tstat[t] == ST_ALLOC && !bound_ever[t]) begin
      bind_timer(t, 4'($urandom_range(15)), $urandom);
    end
    c = make_cmd(MODE_ARM, t);
    c.timeout = tmo;
    send_item(c);
  endtask

  task automatic tick();
    send_item(make_cmd(MODE_TICK, 4'($urandom_range(15))));
  endtask

  task automatic free_timer(input logic [3:0] t);
    send_item(make_cmd(MODE_FREE, t));
  endtask

  task automatic alloc_timer();
    send_item(make_cmd(MODE_ALLOC, 4'($urandom_range(15))));
  endtask

  function automatic logic [3:0] pick_timer(logic [1:0] st);
    logic [3:0] hits[$];
    int i;
    for (i = 0; i < NUM_TIMERS; i++) if (tstat[i] == st) hits.push_back(4'(i));
    if (hits.size() == 0) return 4'($urandom_range(15));
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  // small timeouts, zero, or a wrapped deadline that is already reached
  function automatic logic [31:0] rand_timeout();
    int sel;
    sel = $urandom_range(9);
    if (sel >= 8 && tick_cnt > 0) return TIMEOUT_MAX - $urandom_range(tick_cnt - 1);
    if (sel == 7) return '0;
    return $urandom_range(12);
  endfunction

  task automatic test_alloc_free();
    alloc_timer();
    alloc_timer();
    free_timer(4'd0);
    alloc_timer();
    free_timer(4'd1);
    free_timer(4'd1);
  endtask

  task automatic test_bind_arm_rules();
    bind_timer(4'd0, 4'd15, 32'h7fffffff);
    bind_timer(4'd3, 4'd0, 32'h80000000);
    arm_timer(4'd3, TIMEOUT_MAX);
    arm_timer(4'd0, 32'd2);
    arm_timer(4'd0, 32'd5);
    free_timer(4'd0);
    send_item(make_cmd(MODE_UNUSED_FIRST, 4'd15));
    send_item(make_cmd(MODE_UNUSED_LAST, 4'd0));
  endtask

  task automatic test_tick_order();
    alloc_timer();
    bind_timer(4'd1, 4'd9, 32'hffffffff);
    arm_timer(4'd1, 32'd2);
    tick();
    tick();
    arm_timer(4'd0, TIMEOUT_MAX);
    arm_timer(4'd1, '0);
    tick();
    wait_drain();
  endtask

  task automatic test_full_burst(input int pct);
    int i;
    idle_pct = pct;
    for (i = 0; i <= NUM_TIMERS; i++) alloc_timer();
    for (i = 0; i < NUM_TIMERS; i++) if (tstat[i] == ST_ALLOC) arm_timer(4'(i), 32'd1);
    tick();
    tick();
    for (i = 0; i < NUM_TIMERS; i++) free_timer(4'(i));
    wait_drain();
  endtask

  task automatic test_random_mix(input int n_items);
    int stop_at, sel;
    logic [3:0] t;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      if ($urandom_range(39) == 0) begin
        case ($urandom_range(2))
          0: idle_pct = 0;
          1: idle_pct = 20;
          default: idle_pct = 60;
        endcase
      end
      if ($urandom_range(79) == 0) wait_drain();
      sel = $urandom_range(99);
      if (sel < 24) begin
        tick();
      end else if (sel < 40) begin
        alloc_timer();
      end else if (sel < 52) begin
        bind_timer(4'($urandom_range(15)), 4'($urandom_range(15)), $urandom);
      end else if (sel < 78) begin
        t = ($urandom_range(3) != 0) ? pick_timer(ST_ALLOC) : 4'($urandom_range(15));
        arm_timer(t, (tstat[t] == ST_ALLOC) ? rand_timeout() : 32'($urandom));
      end else if (sel < 96) begin
        t = ($urandom_range(9) < 7) ? pick_timer(ST_ALLOC) : 4'($urandom_range(15));
        free_timer(t);
      end else begin
        send_item(make_cmd(3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST)),
                           4'($urandom_range(15))));
      end
    end
    wait_drain();
  endtask

  initial begin
    tick_cnt = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tstat[i] = ST_FREE;
      bound_ever[i] = 1'b0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_pct = 30;
    test_alloc_free();
    test_bind_arm_rules();
    test_tick_order();
    test_full_burst(0);
    test_full_burst(60);
    test_random_mix(325);
    wait_drain();
    repeat (40) @(posedge clk);
    $display("sent %0d commands, checked %0d results", sent_cnt, checked_cnt);
    $display("%0d expiries (largest burst %0d), %0d refusals, final tick count %0d",
             expiry_cnt, burst_max, refusal_cnt, tick_cnt);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("status: fail");
    $finish;
  end

endmodule
